// ===== design/skvt_pkg.sv =====
`timescale 1ns / 1ps
package skvt_pkg;

    localparam int KEY_W = 128;
    localparam int VAL_W = 192;

    typedef enum logic [1:0] {
        CMD_SEARCH = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_BAD_LEN   = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_TABLE_FULL = 3'd4,
        ST_POOL_FULL = 3'd5
    } status_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic [63:0] val_in_hi;
        logic [63:0] val_in_mid;
        logic [63:0] val_in_lo;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] val_out_hi;
        logic [63:0] val_out_mid;
        logic [63:0] val_out_lo;
        logic [6:0]  entries_held;
    } out_word_t;

    // Datapath control from the sequencer.
    typedef struct packed {
        logic load;       // capture and trim the command word
        logic rd;         // issue a memory read at rd_sel
        logic rd_probe;   // read address is the search probe (else shift source)
        logic cmp;        // compare read key, update search bounds
        logic shift_wr;   // write read entry one slot up
        logic ins_wr;     // write new entry at the insert position
        logic commit;     // bump count and pool use
        logic clear;      // empty the table
        logic shift_init; // set shift pointer to entry count
    } dp_ctrl_t;

    typedef struct packed {
        logic       search_done;
        logic       hit;
        logic       shift_done;
        logic [2:0] ins_status;
    } dp_stat_t;

    // Zero bytes after the first zero byte of a big-endian text.
    function automatic logic [VAL_W-1:0] trim_text(input logic [VAL_W-1:0] w, input int nbytes);
        logic [VAL_W-1:0] r;
        logic ended;
        r = '0;
        ended = 1'b0;
        for (int b = 0; b < 24; b++) begin
            if (b < nbytes) begin
                if (w[VAL_W-1-8*b -: 8] == 8'd0)
                    ended = 1'b1;
                if (!ended)
                    r[VAL_W-1-8*b -: 8] = w[VAL_W-1-8*b -: 8];
            end
        end
        return r;
    endfunction

    function automatic logic [4:0] text_len(input logic [VAL_W-1:0] w, input int nbytes);
        logic [4:0] n;
        logic ended;
        n = '0;
        ended = 1'b0;
        for (int b = 0; b < 24; b++) begin
            if (b < nbytes) begin
                if (w[VAL_W-1-8*b -: 8] == 8'd0)
                    ended = 1'b1;
                if (!ended)
                    n = n + 5'd1;
            end
        end
        return n;
    endfunction

endpackage

// ===== design/skvt_datapath.sv =====
`timescale 1ns / 1ps
module skvt_datapath
    import skvt_pkg::*;
#(
    parameter int MAX_ENTRIES   = 64,
    parameter int POOL_BYTES    = 2048,
    parameter int KEY_LEN_LIMIT = 16,
    parameter int VAL_LEN_LIMIT = 17
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_word_t  in_word,
    input  dp_ctrl_t  ctrl,
    output dp_stat_t  stat,
    output out_word_t res_word
);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int PW = $clog2(POOL_BYTES + 1) + 1;

    logic [KEY_W+VAL_W-1:0] mem [MAX_ENTRIES];
    logic [KEY_W+VAL_W-1:0] rd_data_reg;

    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] val_reg;
    logic [4:0]       klen_reg;
    logic [4:0]       vlen_reg;
    logic [CW-1:0]    count_reg;
    logic [PW-1:0]    pool_reg;
    logic [CW-1:0]    low_reg;
    logic [CW-1:0]    high_reg;
    logic [CW-1:0]    mid_reg;
    logic [CW-1:0]    ptr_reg;
    logic [CW-1:0]    wr_ptr_reg;
    logic             shift_pend_reg;

    logic [VAL_W-1:0] key_wide;
    logic [VAL_W-1:0] key_trim;
    logic [CW-1:0]    probe;
    logic [CW-1:0]    rd_sel;
    logic [CW:0]      lh_sum;
    logic [PW-1:0]    need_total;

    assign key_wide = {in_word.key_hi, in_word.key_lo, 64'd0};
    assign key_trim = trim_text(key_wide, 16);
    assign lh_sum   = {1'b0, low_reg} + {1'b0, high_reg};
    assign probe    = lh_sum[CW:1];
    assign rd_sel   = ctrl.rd_probe ? probe : CW'(ptr_reg - CW'(1));
    assign need_total = pool_reg + PW'(klen_reg) + PW'(vlen_reg) + PW'(2);

    always_ff @(posedge clk)
    begin
        if (ctrl.rd)
            rd_data_reg <= mem[rd_sel[AW-1:0]];
        if (ctrl.shift_wr && shift_pend_reg)
            mem[wr_ptr_reg[AW-1:0]] <= rd_data_reg;
        else if (ctrl.ins_wr)
            mem[low_reg[AW-1:0]] <= {key_reg, val_reg};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            key_reg  <= key_trim[VAL_W-1 -: KEY_W];
            val_reg  <= trim_text({in_word.val_in_hi, in_word.val_in_mid, in_word.val_in_lo}, 24);
            klen_reg <= text_len(key_wide, 16);
            vlen_reg <= text_len({in_word.val_in_hi, in_word.val_in_mid, in_word.val_in_lo}, 24);
        end
        if (ctrl.rd)
            mid_reg <= probe;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            pool_reg       <= '0;
            low_reg        <= '0;
            high_reg       <= '0;
            ptr_reg        <= '0;
            wr_ptr_reg     <= '0;
            shift_pend_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.load)
            begin
                low_reg  <= '0;
                high_reg <= count_reg;
            end
            if (ctrl.cmp)
            begin
                // stored key below search key: move low past mid
                if (rd_data_reg[KEY_W+VAL_W-1 -: KEY_W] < key_reg)
                    low_reg <= CW'(mid_reg + CW'(1));
                else
                    high_reg <= mid_reg;
            end
            if (ctrl.shift_init)
            begin
                ptr_reg        <= count_reg;
                shift_pend_reg <= 1'b0;
            end
            else if (ctrl.shift_wr)
            begin
                // read of ptr-1 lands next cycle; write it one slot up
                if (ptr_reg > low_reg)
                begin
                    wr_ptr_reg <= ptr_reg;
                    ptr_reg    <= CW'(ptr_reg - CW'(1));
                    shift_pend_reg <= 1'b1;
                end
                else
                    shift_pend_reg <= 1'b0;
            end
            if (ctrl.commit)
            begin
                count_reg <= CW'(count_reg + CW'(1));
                pool_reg  <= need_total;
            end
            if (ctrl.clear)
            begin
                count_reg <= '0;
                pool_reg  <= '0;
            end
        end
    end

    logic hit;
    assign hit = (low_reg < count_reg) && (rd_data_reg[KEY_W+VAL_W-1 -: KEY_W] == key_reg);

    always_comb
    begin
        stat.search_done = (low_reg >= high_reg);
        stat.hit         = hit;
        stat.shift_done  = (ptr_reg <= low_reg) && !shift_pend_reg;
        if (klen_reg == 5'd0 || klen_reg > 5'(KEY_LEN_LIMIT) || vlen_reg > 5'(VAL_LEN_LIMIT))
            stat.ins_status = ST_BAD_LEN;
        else if (hit)
            stat.ins_status = ST_DUPLICATE;
        else if (count_reg >= CW'(MAX_ENTRIES))
            stat.ins_status = ST_TABLE_FULL;
        else if (need_total > PW'(POOL_BYTES))
            stat.ins_status = ST_POOL_FULL;
        else
            stat.ins_status = ST_OK;
        res_word.status       = '0;
        res_word.val_out_hi   = rd_data_reg[VAL_W-1 -: 64];
        res_word.val_out_mid  = rd_data_reg[VAL_W-65 -: 64];
        res_word.val_out_lo   = rd_data_reg[63:0];
        res_word.entries_held = 7'(count_reg);
    end
endmodule

// ===== design/skvt_ctrl.sv =====
`timescale 1ns / 1ps
module skvt_ctrl
    import skvt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic [1:0] cmd,
    input  dp_stat_t  stat,
    input  out_word_t dp_word,
    output dp_ctrl_t  ctrl,
    output logic      busy,
    output logic      done,
    output out_word_t result
);
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_PROBE  = 8'b0000_0010,
        S_CMP    = 8'b0000_0100,
        S_FINAL  = 8'b0000_1000,
        S_CHECK  = 8'b0001_0000,
        S_SHIFT  = 8'b0010_0000,
        S_INSERT = 8'b0100_0000,
        S_REPLY  = 8'b1000_0000
    } state_t;

    state_t    state_reg, state_next;
    logic [1:0] cmd_reg;
    logic [2:0] status_reg, status_next;
    logic       show_val_reg, show_val_next;
    logic       done_reg;

    always_comb
    begin
        ctrl          = '0;
        state_next    = state_reg;
        status_next   = status_reg;
        show_val_next = show_val_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load     = 1'b1;
                    status_next   = ST_OK;
                    show_val_next = 1'b0;
                    if (cmd == CMD_SEARCH || cmd == CMD_INSERT)
                        state_next = S_PROBE;
                    else
                    begin
                        ctrl.clear = (cmd == CMD_CLEAR);
                        state_next = S_REPLY;
                    end
                end
            end
            S_PROBE:
            begin
                ctrl.rd = 1'b1;
                ctrl.rd_probe = 1'b1;
                state_next = stat.search_done ? S_FINAL : S_CMP;
            end
            S_CMP:
            begin
                ctrl.cmp   = 1'b1;
                state_next = S_PROBE;
            end
            S_FINAL:
            begin
                // read at low is now registered
                if (cmd_reg == CMD_SEARCH)
                begin
                    status_next   = stat.hit ? ST_OK : ST_NOT_FOUND;
                    show_val_next = stat.hit;
                    state_next    = S_REPLY;
                end
                else
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                status_next = stat.ins_status;
                if (stat.ins_status == ST_OK)
                begin
                    ctrl.shift_init = 1'b1;
                    state_next      = S_SHIFT;
                end
                else
                    state_next = S_REPLY;
            end
            S_SHIFT:
            begin
                ctrl.rd       = 1'b1;
                ctrl.shift_wr = 1'b1;
                if (stat.shift_done)
                    state_next = S_INSERT;
            end
            S_INSERT:
            begin
                ctrl.ins_wr = 1'b1;
                ctrl.commit = 1'b1;
                state_next  = S_REPLY;
            end
            S_REPLY:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cmd_reg      <= CMD_SEARCH;
            status_reg   <= ST_OK;
            show_val_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            status_reg   <= status_next;
            show_val_reg <= show_val_next;
            done_reg     <= (state_reg == S_REPLY);
            if (state_reg == S_IDLE && start)
                cmd_reg <= cmd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_REPLY)
        begin
            result.status       <= status_reg;
            result.val_out_hi   <= show_val_reg ? dp_word.val_out_hi : '0;
            result.val_out_mid  <= show_val_reg ? dp_word.val_out_mid : '0;
            result.val_out_lo   <= show_val_reg ? dp_word.val_out_lo : '0;
            result.entries_held <= dp_word.entries_held;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
endmodule

// ===== design/sorted_key_value_table_core.sv =====
`timescale 1ns / 1ps
// Sorted key/value table with search, insert and clear commands.
// Input channel: drive cmd_word and raise start; the word is taken at a
//   rising edge where start is high and busy is low.
// Output channel: done pulses for one cycle with res_word; the receiver
//   cannot hold it off, so capture it in that cycle.
// Sequence: a search makes one memory read and one key compare per
//   binary-search probe, then reads at the final low bound and replies.
//   Clear and the unused code go straight from the accept to the reply.
//   An insert adds a length, duplicate and space check, the shift (a
//   read-write pipe moves each entry above the insert position one slot
//   up) and one write of the new entry.
// One command is in flight at a time; busy stays high until done.
// Reset empties the table (count and pool usage go to zero); the entry
//   memory keeps no reset and its contents are only used below the entry count.
module sorted_key_value_table_core
    import skvt_pkg::*;
#(
    parameter int MAX_ENTRIES   = 64,
    parameter int POOL_BYTES    = 2048,
    parameter int KEY_LEN_LIMIT = 16,
    parameter int VAL_LEN_LIMIT = 17
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_word_t  cmd_word,
    output logic      done,
    output out_word_t res_word
);
    dp_ctrl_t  ctrl;
    dp_stat_t  stat;
    out_word_t dp_word;

    // sequencer: walk search, checks, shift, insert, clear and reply
    skvt_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .cmd     (cmd_word.cmd),
        .stat    (stat),
        .dp_word (dp_word),
        .ctrl    (ctrl),
        .busy    (busy),
        .done    (done),
        .result  (res_word)
    );

    // datapath: entry memory, bounds, count and pool registers
    skvt_datapath #(
        .MAX_ENTRIES   (MAX_ENTRIES),
        .POOL_BYTES    (POOL_BYTES),
        .KEY_LEN_LIMIT (KEY_LEN_LIMIT),
        .VAL_LEN_LIMIT (VAL_LEN_LIMIT)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (cmd_word),
        .ctrl     (ctrl),
        .stat     (stat),
        .res_word (dp_word)
    );
endmodule

// ===== design/skvt_checker.sv =====
`timescale 1ns / 1ps
module skvt_checker
    import skvt_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input logic      busy,
    input logic      done,
    input out_word_t res_word
);
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("accepted word did not raise busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> res_word.status <= ST_POOL_FULL) else $error("bad status");
    a_noval: assert property (@(posedge clk) disable iff (!rst_n)
        done && res_word.status != ST_OK |-> res_word.val_out_hi == 64'd0)
        else $error("value shown on failure");
endmodule

bind sorted_key_value_table_core skvt_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(done), .res_word(res_word)
);
